// ===== rtl/core/sqb_pkg.sv =====
// Shared types, state encoding and constants of the sprite quad batcher.
package sqb_pkg;

	localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
	localparam int unsigned TERMS = 12;

	typedef struct packed {
		logic        mode;
		logic [15:0] texture_id;
		logic [23:0] texture_size;
		logic [31:0] origin_xy;
		logic [31:0] scale_xy;
		logic [15:0] angle;
		logic [31:0] position_xy;
		logic [31:0] rect_origin;
		logic [31:0] rect_size;
		logic [31:0] color;
	} sprite_t;

	typedef struct packed {
		logic               kind;
		logic [15:0]        batch_texture;
		logic [10:0]        batch_vertices;
		logic signed [15:0] vertex_x;
		logic signed [15:0] vertex_y;
		logic [15:0]        tex_u;
		logic [15:0]        tex_v;
		logic [31:0]        vertex_color;
		logic               last;
	} vertex_t;

	localparam logic MODE_DRAW  = 1'b0;
	localparam logic MODE_FLUSH = 1'b1;
	localparam logic KIND_FLUSH  = 1'b0;
	localparam logic KIND_VERTEX = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FLUSH,
		ST_SETUP1,
		ST_SETUP2,
		ST_DFLUSH,
		ST_VMUL,
		ST_VOUT
	} state_t;

	typedef struct packed {
		logic       load;
		logic       setup1;
		logic       setup2;
		logic       vmul;
		logic       emit_flush;
		logic       emit_vertex;
		logic [1:0] corner;
	} cmd_t;

	typedef struct packed {
		logic req_mode;
		logic need_flush;
		logic out_free;
	} status_t;

endpackage

// ===== rtl/core/sqb_ctrl.sv =====
// Sequencing state machine of the sprite quad batcher.
module sqb_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	output logic            req_stall,
	input  sqb_pkg::status_t st,
	output sqb_pkg::cmd_t    cmd
);
	import sqb_pkg::*;

	state_t     state_q, state_next;
	logic [1:0] corner_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			corner_q <= 2'd0;
		end else begin
			state_q <= state_next;
			if (state_q == ST_SETUP2) begin
				corner_q <= 2'd0;
			end else if (state_q == ST_VOUT && st.out_free) begin
				corner_q <= corner_q + 2'd1;
			end
		end
	end

	always_comb begin
		state_next = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					state_next = (st.req_mode == MODE_FLUSH) ? ST_FLUSH : ST_SETUP1;
				end
			end
			ST_FLUSH: begin
				if (st.out_free) begin
					state_next = ST_IDLE;
				end
			end
			ST_SETUP1: state_next = ST_SETUP2;
			ST_SETUP2: state_next = st.need_flush ? ST_DFLUSH : ST_VMUL;
			ST_DFLUSH: begin
				if (st.out_free) begin
					state_next = ST_VMUL;
				end
			end
			ST_VMUL: state_next = ST_VOUT;
			ST_VOUT: begin
				if (st.out_free) begin
					state_next = (corner_q == 2'd3) ? ST_IDLE : ST_VMUL;
				end
			end
			default: state_next = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd             = '0;
		cmd.corner      = corner_q;
		req_stall       = (state_q != ST_IDLE);
		cmd.load        = (state_q == ST_IDLE) && req_valid;
		cmd.setup1      = (state_q == ST_SETUP1);
		cmd.setup2      = (state_q == ST_SETUP2);
		cmd.vmul        = (state_q == ST_VMUL);
		cmd.emit_flush  = (state_q == ST_FLUSH || state_q == ST_DFLUSH) && st.out_free;
		cmd.emit_vertex = (state_q == ST_VOUT) && st.out_free;
	end

endmodule

// ===== rtl/core/sqb_datapath.sv =====
// Batch state, corner transform, sine table and output register.
module sqb_datapath #(
	parameter int BATCH_VERTICES = 1024,
	parameter int SINE_ENTRIES   = 1024
) (
	input  logic             clk,
	input  logic             arst_n,
	input  sqb_pkg::sprite_t req,
	input  sqb_pkg::cmd_t    cmd,
	output sqb_pkg::status_t st,
	input  logic             rsp_stall,
	output logic             rsp_valid,
	output sqb_pkg::vertex_t rsp
);
	import sqb_pkg::*;

	localparam int CW = $clog2(BATCH_VERTICES + 1);
	localparam int AW = $clog2(SINE_ENTRIES + 1);
	localparam int IW = $clog2(SINE_ENTRIES);
	localparam longint unsigned Denom [TERMS] =
		'{6, 20, 42, 72, 110, 156, 210, 272, 342, 420, 506, 600};

	typedef logic [14:0] sine_tab_t [SINE_ENTRIES];

	function automatic sine_tab_t build_table();
		sine_tab_t        tab;
		longint unsigned th, th2, term, e;
		longint           sum;
		for (int i = 0; i < SINE_ENTRIES; i++) begin
			th   = (HALF_PI_Q30 * longint'(i)) / SINE_ENTRIES;
			th2  = (th * th) >> 30;
			term = th;
			sum  = 0;
			for (int k = 0; k < TERMS; k++) begin
				if (k % 2 == 0) sum = sum + longint'(term);
				else sum = sum - longint'(term);
				term = ((term * th2) >> 30) / Denom[k];
			end
			if (sum < 0) sum = 0;
			e = (longint'(sum) + 64'd32768) >> 16;
			if (e > 64'd16384) e = 64'd16384;
			tab[i] = e[14:0];
		end
		return tab;
	endfunction

	localparam sine_tab_t SINE_TABLE = build_table();

	sprite_t         req_q;
	logic            mode_q;
	logic            need_flush_q;
	logic [15:0]     fl_tex_q;
	logic [10:0]     fl_cnt_q;
	logic [CW-1:0]   cnt_q;
	logic [15:0]     open_tex_q;
	logic            open_q;
	logic            rsp_valid_q;
	vertex_t         rsp_q;
	logic            need_flush;
	logic [31:0]     cnt_wide;

	logic [14:0]        rom_s1 [2];
	logic               full_s1 [2];
	logic               neg_s1 [2];
	logic [31:0]        oxsx_s1, oysy_s1;
	logic [27:0]        wsx_s1, hsy_s1;
	logic signed [15:0] trig_s2 [2];
	logic signed [33:0] cx0_s2, cx1_s2, cy0_s2, cy1_s2;
	logic signed [49:0] pxc_s3, pys_s3, pxs_s3, pyc_s3;

	logic [15:0]        ang [2];
	logic [13+AW:0]     iprod [2];
	logic [AW-1:0]      idx [2];
	logic [AW-1:0]      addr [2];

	assign cnt_wide   = 32'(cnt_q);
	assign need_flush = open_q && (((CW+1)'(cnt_q) + (CW+1)'(4) > (CW+1)'(BATCH_VERTICES))
		|| (req.texture_id != open_tex_q));

	assign st.req_mode   = req.mode;
	assign st.need_flush = need_flush_q;
	assign st.out_free   = !rsp_valid_q || !rsp_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q      <= '0;
			open_tex_q <= '0;
			open_q     <= 1'b0;
		end else if (cmd.load) begin
			if (req.mode == MODE_FLUSH) begin
				cnt_q      <= '0;
				open_tex_q <= '0;
				open_q     <= 1'b0;
			end else if (need_flush || !open_q) begin
				cnt_q      <= CW'(4);
				open_tex_q <= req.texture_id;
				open_q     <= 1'b1;
			end else begin
				cnt_q <= cnt_q + CW'(4);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_q        <= req;
			mode_q       <= req.mode;
			need_flush_q <= need_flush;
			fl_tex_q     <= open_q ? open_tex_q : 16'd0;
			fl_cnt_q     <= open_q ? cnt_wide[10:0] : 11'd0;
		end
	end

	always_comb begin
		ang[0] = req_q.angle;
		ang[1] = req_q.angle + 16'h4000;
		for (int j = 0; j < 2; j++) begin
			iprod[j] = (14+AW)'(ang[j][13:0]) * (14+AW)'(SINE_ENTRIES);
			idx[j]   = iprod[j][13+AW:14];
			addr[j]  = ang[j][14] ? (AW'(SINE_ENTRIES) - idx[j]) : idx[j];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.setup1) begin
			for (int j = 0; j < 2; j++) begin
				rom_s1[j]  <= SINE_TABLE[addr[j][IW-1:0]];
				full_s1[j] <= (addr[j] == AW'(SINE_ENTRIES));
				neg_s1[j]  <= ang[j][15];
			end
			oxsx_s1 <= 32'(req_q.origin_xy[15:0]) * 32'(req_q.scale_xy[15:0]);
			oysy_s1 <= 32'(req_q.origin_xy[31:16]) * 32'(req_q.scale_xy[31:16]);
			wsx_s1  <= 28'(req_q.texture_size[11:0]) * 28'(req_q.scale_xy[15:0]);
			hsy_s1  <= 28'(req_q.texture_size[23:12]) * 28'(req_q.scale_xy[31:16]);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.setup2) begin
			for (int j = 0; j < 2; j++) begin
				logic signed [15:0] mag;
				mag = full_s1[j] ? 16'sd16384 : $signed({1'b0, rom_s1[j]});
				trig_s2[j] <= neg_s1[j] ? -mag : mag;
			end
			cx0_s2 <= -$signed({2'b00, oxsx_s1});
			cx1_s2 <= -$signed({2'b00, oxsx_s1}) + $signed({2'b00, wsx_s1, 4'b0000});
			cy0_s2 <= -$signed({2'b00, oysy_s1});
			cy1_s2 <= -$signed({2'b00, oysy_s1}) + $signed({2'b00, hsy_s1, 4'b0000});
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.vmul) begin
			logic signed [33:0] cx, cy;
			cx = (cmd.corner == 2'd1 || cmd.corner == 2'd2) ? cx1_s2 : cx0_s2;
			cy = (cmd.corner == 2'd2 || cmd.corner == 2'd3) ? cy1_s2 : cy0_s2;
			pxc_s3 <= 50'(cx) * 50'(trig_s2[1]);
			pys_s3 <= 50'(cy) * 50'(trig_s2[0]);
			pxs_s3 <= 50'(cx) * 50'(trig_s2[0]);
			pyc_s3 <= 50'(cy) * 50'(trig_s2[1]);
		end
	end

	function automatic logic signed [15:0] sat16(input logic signed [29:0] v);
		if (v > 30'sd32767) return 16'sh7FFF;
		if (v < -30'sd32768) return 16'sh8000;
		return v[15:0];
	endfunction

	function automatic logic [15:0] usat(input logic [15:0] a, input logic [15:0] b);
		logic [16:0] s;
		s = 17'(a) + 17'(b);
		return s[16] ? 16'hFFFF : s[15:0];
	endfunction

	logic signed [50:0] sum_x, sum_y;
	logic signed [29:0] rx, ry;
	logic [15:0]        u1, v1;

	always_comb begin
		sum_x = 51'(pxc_s3) - 51'(pys_s3) + 51'sd2097152;
		sum_y = 51'(pxs_s3) + 51'(pyc_s3) + 51'sd2097152;
		rx = 30'($signed(sum_x[50:22])) + 30'($signed(req_q.position_xy[15:0]));
		ry = 30'($signed(sum_y[50:22])) + 30'($signed(req_q.position_xy[31:16]));
		u1 = usat(req_q.rect_origin[15:0], req_q.rect_size[15:0]);
		v1 = usat(req_q.rect_origin[31:16], req_q.rect_size[31:16]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (cmd.emit_flush || cmd.emit_vertex) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit_flush) begin
			rsp_q <= '{kind: KIND_FLUSH, batch_texture: fl_tex_q, batch_vertices: fl_cnt_q,
				vertex_x: 16'sd0, vertex_y: 16'sd0, tex_u: 16'd0, tex_v: 16'd0,
				vertex_color: 32'd0, last: (mode_q == MODE_FLUSH)};
		end else if (cmd.emit_vertex) begin
			rsp_q.kind           <= KIND_VERTEX;
			rsp_q.batch_texture  <= '0;
			rsp_q.batch_vertices <= '0;
			rsp_q.vertex_x       <= sat16(rx);
			rsp_q.vertex_y       <= sat16(ry);
			rsp_q.tex_u          <= (cmd.corner == 2'd1 || cmd.corner == 2'd2) ?
				u1 : req_q.rect_origin[15:0];
			rsp_q.tex_v          <= (cmd.corner == 2'd2 || cmd.corner == 2'd3) ?
				v1 : req_q.rect_origin[31:16];
			rsp_q.vertex_color   <= req_q.color;
			rsp_q.last           <= (cmd.corner == 2'd3);
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

// ===== rtl/core/sprite_quad_batcher_unit.sv =====
// Sprite quad batcher: one draw transaction in, an optional flush and four vertices out.
// A draw transaction passes the load and setup states (SETUP1, SETUP2), a flush state when a
// flush result comes first, then a product stage and the output register for each vertex.
// A flush transaction emits only a flush result. Each result waits while the output stalls.
// The input is stalled until the last result of a transaction is loaded in the output register.
// Reset closes the open batch, clears the vertex count and empties the output register.
module sprite_quad_batcher_unit #(
	parameter int BATCH_VERTICES = 1024,
	parameter int SINE_ENTRIES   = 1024
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	output logic             req_stall,
	input  sqb_pkg::sprite_t req,
	output logic             rsp_valid,
	input  logic             rsp_stall,
	output sqb_pkg::vertex_t rsp
);
	import sqb_pkg::*;

	cmd_t    cmd;
	status_t st;

	sqb_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.st        (st),
		.cmd       (cmd)
	);

	sqb_datapath #(
		.BATCH_VERTICES (BATCH_VERTICES),
		.SINE_ENTRIES   (SINE_ENTRIES)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cmd       (cmd),
		.st        (st),
		.rsp_stall (rsp_stall),
		.rsp_valid (rsp_valid),
		.rsp       (rsp)
	);

endmodule

// ===== rtl/core/sqb_checker.sv =====
// Port-level checks of the sprite quad batcher and their binding to the top level.
module sqb_checker (
	input logic             clk,
	input logic             arst_n,
	input logic             req_valid,
	input logic             req_stall,
	input sqb_pkg::sprite_t req,
	input logic             rsp_valid,
	input logic             rsp_stall,
	input sqb_pkg::vertex_t rsp
);
	import sqb_pkg::*;

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("Stalled result transaction changed.");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> req_stall)
		else $error("Input accepted a second transaction while busy.");

	a_flush_fields: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.kind == KIND_FLUSH |->
		rsp.vertex_x == 16'sd0 && rsp.vertex_y == 16'sd0 && rsp.tex_u == 16'd0 &&
		rsp.tex_v == 16'd0 && rsp.vertex_color == 32'd0)
		else $error("Flush result carries vertex fields.");

	a_vertex_fields: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.kind == KIND_VERTEX |->
		rsp.batch_texture == 16'd0 && rsp.batch_vertices == 11'd0)
		else $error("Vertex result carries batch fields.");

endmodule

bind sprite_quad_batcher_unit sqb_checker u_sqb_checker (.*);
